// File: rtl/core/websocket_frame_parser_unit_macros.svh
// Assertion macros shared by the frame parser RTL.
// Assertions are checked in simulation and left out for synthesis.
`ifndef WEBSOCKET_FRAME_PARSER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define WSFP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("frame parser assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define WSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`else

`define WSFP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define WSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/wsfp_pkg.sv
// Types and constants for the WebSocket frame parser.
// No dependencies; used by wsfp_step and websocket_frame_parser_unit.
package wsfp_pkg;

  localparam logic [7:0] FIN_BIT_MASK = 8'h80;
  localparam logic [7:0] OPCODE_MASK  = 8'h0F;
  localparam logic [7:0] LEN_MASK     = 8'h7F;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_IGNORE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic       frame_end;
    logic       status;
    logic       final_fragment;
    logic [3:0] frame_opcode;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  header_count;
    logic        fin_flag;
    logic [3:0]  opcode;
    logic        masked_flag;
    logic [63:0] frame_length;
    logic [31:0] key_word;
    logic [63:0] payload_count;
  } parse_state_t;

endpackage

// File: rtl/core/websocket_frame_parser_unit.sv
// WebSocket frame parser: one received byte per beat, at most one result per beat.
// Each accepted byte is held in an input register; its result is then registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the parser state advances once per byte.
// Reset: synchronous, active low; parser returns to the first header byte, both
// pipeline registers empty.
// Depends on wsfp_pkg, wsfp_step and websocket_frame_parser_unit_macros.svh.
`include "websocket_frame_parser_unit_macros.svh"

module websocket_frame_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wsfp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output wsfp_pkg::out_item_t out_item
);

  logic                   in_valid_r;
  wsfp_pkg::in_item_t     in_item_r;
  wsfp_pkg::parse_state_t state_r;
  wsfp_pkg::parse_state_t state_nxt;
  wsfp_pkg::out_item_t    result;
  logic                   emit;
  logic                   out_valid_r;
  wsfp_pkg::out_item_t    out_item_r;
  logic                   advance;

  // The held byte moves on whenever the output register is free or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  wsfp_step u_step (
    .state_r   (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= wsfp_pkg::PH_HDR0;
      state_r.header_count  <= '0;
      state_r.fin_flag      <= 1'b0;
      state_r.opcode        <= '0;
      state_r.masked_flag   <= 1'b0;
      state_r.frame_length  <= '0;
      state_r.key_word      <= '0;
      state_r.payload_count <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `WSFP_ASSERT_ALWAYS(a_payload_in_range, clk, rst_n,
    (state_r.phase != wsfp_pkg::PH_PAYLOAD) || (state_r.payload_count < state_r.frame_length))
  `WSFP_ASSERT_ALWAYS(a_key_count, clk, rst_n,
    (state_r.phase != wsfp_pkg::PH_KEY) ||
    (state_r.masked_flag && state_r.header_count != 4'd0 &&
     state_r.header_count <= wsfp_pkg::KEY_BYTES))
  `WSFP_ASSERT_ALWAYS(a_data_not_truncated, clk, rst_n,
    !(out_valid_r && out_item_r.has_data && out_item_r.status))
  `WSFP_ASSERT_NEXT(a_held_byte_stable, clk, rst_n,
    in_valid_r && !advance, in_valid_r && $stable(in_item_r))
  `WSFP_ASSERT_NEXT(a_emit_reaches_output, clk, rst_n, advance && emit, out_valid_r)

endmodule

// File: rtl/core/wsfp_step.sv
// Next-state and result logic for one received byte of the frame parser.
// Depends on wsfp_pkg for the state, item and phase types.
module wsfp_step (
  input  wsfp_pkg::parse_state_t state_r,
  input  wsfp_pkg::in_item_t     item,
  output wsfp_pkg::parse_state_t state_nxt,
  output wsfp_pkg::out_item_t    result,
  output logic                   emit
);

  logic [7:0] b;
  logic [6:0] len_code;
  logic       do_after_len;
  logic       do_body;
  logic [7:0] key_byte;
  logic [63:0] count_inc;

  always_comb begin
    b            = item.rx_byte;
    len_code     = b[6:0] & wsfp_pkg::LEN_MASK[6:0];
    do_after_len = 1'b0;
    do_body      = 1'b0;
    state_nxt    = state_r;
    result       = '0;
    emit         = 1'b0;
    count_inc    = state_r.payload_count + 64'd1;

    case (state_r.payload_count[1:0])
      2'd0:    key_byte = state_r.key_word[31:24];
      2'd1:    key_byte = state_r.key_word[23:16];
      2'd2:    key_byte = state_r.key_word[15:8];
      default: key_byte = state_r.key_word[7:0];
    endcase

    unique case (state_r.phase)
      wsfp_pkg::PH_HDR0: begin
        state_nxt.fin_flag      = |(b & wsfp_pkg::FIN_BIT_MASK);
        state_nxt.opcode        = 4'(b & wsfp_pkg::OPCODE_MASK);
        state_nxt.masked_flag   = 1'b0;
        state_nxt.frame_length  = '0;
        state_nxt.key_word      = '0;
        state_nxt.payload_count = '0;
        state_nxt.header_count  = '0;
        state_nxt.phase         = wsfp_pkg::PH_HDR1;
      end
      wsfp_pkg::PH_HDR1: begin
        state_nxt.masked_flag  = |(b & wsfp_pkg::FIN_BIT_MASK);
        state_nxt.frame_length = '0;
        if (len_code == wsfp_pkg::LEN_CODE_16) begin
          state_nxt.header_count = wsfp_pkg::EXT16_BYTES;
          state_nxt.phase        = wsfp_pkg::PH_EXTLEN;
        end else if (len_code == wsfp_pkg::LEN_CODE_64) begin
          state_nxt.header_count = wsfp_pkg::EXT64_BYTES;
          state_nxt.phase        = wsfp_pkg::PH_EXTLEN;
        end else begin
          state_nxt.frame_length = {57'd0, len_code};
          do_after_len           = 1'b1;
        end
      end
      wsfp_pkg::PH_EXTLEN: begin
        state_nxt.frame_length = {state_r.frame_length[55:0], b};
        state_nxt.header_count = state_r.header_count - 4'd1;
        do_after_len           = (state_nxt.header_count == 4'd0);
      end
      wsfp_pkg::PH_KEY: begin
        state_nxt.key_word     = {state_r.key_word[23:0], b};
        state_nxt.header_count = state_r.header_count - 4'd1;
        do_body                = (state_nxt.header_count == 4'd0);
      end
      wsfp_pkg::PH_PAYLOAD: begin
        state_nxt.payload_count = count_inc;
        result.payload_byte     = b ^ key_byte;
        result.has_data         = 1'b1;
        emit                    = 1'b1;
        if (count_inc == state_r.frame_length) begin
          result.frame_end = 1'b1;
          state_nxt.phase  = wsfp_pkg::PH_IGNORE;
        end
      end
      default: begin
      end
    endcase

    // Length is known: collect the key, or go straight to the body.
    if (do_after_len) begin
      state_nxt.key_word = '0;
      if (state_nxt.masked_flag) begin
        state_nxt.header_count = wsfp_pkg::KEY_BYTES;
        state_nxt.phase        = wsfp_pkg::PH_KEY;
      end else begin
        do_body = 1'b1;
      end
    end

    // A frame with an empty body completes as soon as its header does.
    if (do_body) begin
      state_nxt.payload_count = '0;
      if (state_nxt.frame_length == 64'd0) begin
        result.frame_end = 1'b1;
        emit             = 1'b1;
        state_nxt.phase  = wsfp_pkg::PH_IGNORE;
      end else begin
        state_nxt.phase = wsfp_pkg::PH_PAYLOAD;
      end
    end

    // The buffer ended inside a frame: report it truncated instead.
    if (item.buffer_end) begin
      if (state_nxt.phase == wsfp_pkg::PH_HDR1 ||
          state_nxt.phase == wsfp_pkg::PH_EXTLEN ||
          state_nxt.phase == wsfp_pkg::PH_KEY ||
          state_nxt.phase == wsfp_pkg::PH_PAYLOAD) begin
        result.payload_byte = '0;
        result.has_data     = 1'b0;
        result.frame_end    = 1'b1;
        result.status       = 1'b1;
        emit                = 1'b1;
      end
      state_nxt.phase        = wsfp_pkg::PH_HDR0;
      state_nxt.header_count = '0;
    end

    result.final_fragment = state_nxt.fin_flag;
    result.frame_opcode   = state_nxt.opcode;
  end

endmodule
